FILE: hw/rtl/exsm_pkg.sv
// ----------------------------------------------------------------------------
// exsm_pkg
// Shared types, codes and the next-state functions of the execution state
// machine.
// ----------------------------------------------------------------------------
package exsm_pkg;

  localparam int unsigned StateW = 5;
  localparam int unsigned OrderW = 4;

  typedef enum logic [StateW-1:0] {
    ST_IDLE         = 5'd0,
    ST_STARTING     = 5'd1,
    ST_EXECUTE      = 5'd2,
    ST_COMPLETING   = 5'd3,
    ST_COMPLETE     = 5'd4,
    ST_RESETTING    = 5'd5,
    ST_HOLDING      = 5'd6,
    ST_HELD         = 5'd7,
    ST_UNHOLDING    = 5'd8,
    ST_SUSPENDING   = 5'd9,
    ST_SUSPENDED    = 5'd10,
    ST_UNSUSPENDING = 5'd11,
    ST_STOPPING     = 5'd12,
    ST_STOPPED      = 5'd13,
    ST_ABORTING     = 5'd14,
    ST_ABORTED      = 5'd15,
    ST_CLEARING     = 5'd16
  } exec_state_e;

  typedef enum logic [OrderW-1:0] {
    OR_START     = 4'd0,
    OR_RESET     = 4'd1,
    OR_HOLD      = 4'd2,
    OR_UNHOLD    = 4'd3,
    OR_SUSPEND   = 4'd4,
    OR_UNSUSPEND = 4'd5,
    OR_ABORT     = 4'd6,
    OR_STOP      = 4'd7,
    OR_CLEAR     = 4'd8,
    OR_COMPLETE  = 4'd9
  } order_e;

  // Event kinds carried on the input side-band.
  localparam logic KIND_ORDER  = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // State after an order; unlisted orders keep the state.
  function automatic exec_state_e after_order(exec_state_e s, logic [OrderW-1:0] o);
    exec_state_e n;
    n = s;
    unique case (s)
      ST_IDLE: begin
        if (o == OR_START) n = ST_STARTING;
        else if (o == OR_STOP) n = ST_STOPPING;
        else if (o == OR_ABORT) n = ST_ABORTING;
      end
      ST_EXECUTE: begin
        if (o == OR_COMPLETE) n = ST_COMPLETING;
        else if (o == OR_HOLD) n = ST_HOLDING;
        else if (o == OR_SUSPEND) n = ST_SUSPENDING;
        else if (o == OR_STOP) n = ST_STOPPING;
        else if (o == OR_ABORT) n = ST_ABORTING;
      end
      ST_COMPLETE, ST_STOPPED: begin
        if (o == OR_RESET) n = ST_RESETTING;
        else if (o == OR_STOP && s == ST_COMPLETE) n = ST_STOPPING;
        else if (o == OR_ABORT) n = ST_ABORTING;
      end
      ST_HELD: begin
        if (o == OR_UNHOLD) n = ST_UNHOLDING;
        else if (o == OR_STOP) n = ST_STOPPING;
        else if (o == OR_ABORT) n = ST_ABORTING;
      end
      ST_SUSPENDED: begin
        if (o == OR_UNSUSPEND) n = ST_UNSUSPENDING;
        else if (o == OR_STOP) n = ST_STOPPING;
        else if (o == OR_ABORT) n = ST_ABORTING;
      end
      ST_STARTING, ST_COMPLETING, ST_RESETTING, ST_HOLDING,
      ST_UNHOLDING, ST_SUSPENDING, ST_UNSUSPENDING: begin
        if (o == OR_STOP) n = ST_STOPPING;
        else if (o == OR_ABORT) n = ST_ABORTING;
      end
      ST_STOPPING, ST_CLEARING: begin
        if (o == OR_ABORT) n = ST_ABORTING;
      end
      ST_ABORTED: begin
        if (o == OR_CLEAR) n = ST_CLEARING;
      end
      default: n = s;
    endcase
    return n;
  endfunction

  // State after the acting state reports it is done.
  function automatic exec_state_e after_finish(exec_state_e s);
    exec_state_e n;
    unique case (s)
      ST_STARTING:     n = ST_EXECUTE;
      ST_EXECUTE:      n = ST_COMPLETING;
      ST_COMPLETING:   n = ST_COMPLETE;
      ST_RESETTING:    n = ST_IDLE;
      ST_HOLDING:      n = ST_HELD;
      ST_UNHOLDING:    n = ST_EXECUTE;
      ST_SUSPENDING:   n = ST_SUSPENDED;
      ST_UNSUSPENDING: n = ST_EXECUTE;
      ST_STOPPING:     n = ST_STOPPED;
      ST_STOPPED:      n = ST_IDLE;
      ST_ABORTING:     n = ST_ABORTED;
      ST_CLEARING:     n = ST_STOPPED;
      default:         n = s;
    endcase
    return n;
  endfunction

endpackage

FILE: hw/rtl/execution_state_machine_unit.sv
// ----------------------------------------------------------------------------
// execution_state_machine_unit
// PackML-style execution state machine with stream-style event input and
// state report output.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_*: one event per transfer. tuser = kind (0 order,
//   1 current acting state finished), tdata[3:0] = order code.
//   Master channel m_axis_*: one result per event. tdata[4:0] = state after
//   the event, tuser = 1 when the event moved the state.
// Output: a result appears on m_axis in the cycle after its event transfer.
// Throughput: one event per cycle while results are taken. The next state is
//   a combinational table lookup on the state register and the event, and the
//   result register is loaded in the same cycle the state register moves.
// Stall: while a result waits in the output register and the receiver holds
//   m_axis_tready low, s_axis_tready is low; when the receiver takes the
//   result, a new event is accepted in that same cycle.
// Reset: the state returns to idle and the output register is emptied.
//   Orders not listed for the current state and finish events in states
//   without a finish step give a result with the state kept and tuser = 0.
// ----------------------------------------------------------------------------
module execution_state_machine_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Event input
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] order_code, [7:4] zero
  input  logic       s_axis_tuser,   // [0] kind
  // Result output
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [4:0] exec_state, [7:5] zero
  output logic       m_axis_tuser    // [0] state_changed
);

  exsm_pkg::exec_state_e state_q, state_d;
  logic                  out_valid_q;
  exsm_pkg::exec_state_e out_state_q;
  logic                  out_changed_q;
  logic                  in_xfer;

  // Output register frees up when empty or when its result is taken.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Next-state lookup; the order code is ignored for finish events.
  always_comb begin
    if (s_axis_tuser == exsm_pkg::KIND_FINISH) begin
      state_d = exsm_pkg::after_finish(state_q);
    end else begin
      state_d = exsm_pkg::after_order(state_q,
                                      s_axis_tdata[exsm_pkg::OrderW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= exsm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_state_q   <= state_d;
      out_changed_q <= (state_d != state_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_state_q};
  assign m_axis_tuser  = out_changed_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An accepted event always leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> m_axis_tvalid)
    else $error("event transfer produced no result");

  // The pending result always reports the live state.
  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_state_q == state_q))
    else $error("reported state differs from state register");

  // A changed flag means the state register really moved on that transfer.
  a_changed_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (state_d != state_q) |=> (state_q != $past(state_q)))
    else $error("state change flagged but state register held");

  // The state register never leaves the defined code range.
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q <= exsm_pkg::ST_CLEARING)
    else $error("state register outside defined codes");

endmodule

FILE: sim/execution_state_machine_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// execution_state_machine_unit_tb
// Self-checking bench for the execution state machine. A directed walk moves
// through every state and order, then random event sequences run under three
// handshake mixes. Each result transfer is checked against a state tracker
// kept in the bench.
// ----------------------------------------------------------------------------
module execution_state_machine_unit_tb;

  localparam int unsigned StallLimit = 2000;  // cycles without any transfer
  localparam int unsigned MaxReports = 10;

  // One expected state report: the state after the event and the moved flag.
  typedef struct packed {
    exsm_pkg::exec_state_e state;
    logic                  moved;
  } state_report_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [3:0] order_code, [7:4] zero
  logic       s_axis_tuser;   // [0] kind
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [4:0] exec_state, [7:5] zero
  logic       m_axis_tuser;   // [0] state_changed

  execution_state_machine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Bench copy of the machine state, advanced at each accepted event
  exsm_pkg::exec_state_e tracked_state;
  state_report_t         state_reports_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned events_sent;
  int unsigned reports_checked;
  int unsigned moves_seen;
  int unsigned mismatch_count;
  int unsigned stall_cycles;
  logic [16:0] states_reached;

  // Next state of the machine for one event. Abort and stop are handled as
  // broad rules, then the orders that belong to particular states.
  function automatic exsm_pkg::exec_state_e predict_next(exsm_pkg::exec_state_e cur,
                                                         logic kind, logic [3:0] code);
    exsm_pkg::exec_state_e nxt;
    nxt = cur;
    if (kind == exsm_pkg::KIND_FINISH) begin
      case (cur)
        exsm_pkg::ST_STARTING, exsm_pkg::ST_UNHOLDING,
        exsm_pkg::ST_UNSUSPENDING: nxt = exsm_pkg::ST_EXECUTE;
        exsm_pkg::ST_EXECUTE:    nxt = exsm_pkg::ST_COMPLETING;
        exsm_pkg::ST_COMPLETING: nxt = exsm_pkg::ST_COMPLETE;
        exsm_pkg::ST_RESETTING:  nxt = exsm_pkg::ST_IDLE;
        exsm_pkg::ST_HOLDING:    nxt = exsm_pkg::ST_HELD;
        exsm_pkg::ST_SUSPENDING: nxt = exsm_pkg::ST_SUSPENDED;
        exsm_pkg::ST_STOPPING:   nxt = exsm_pkg::ST_STOPPED;
        exsm_pkg::ST_STOPPED:    nxt = exsm_pkg::ST_IDLE;
        exsm_pkg::ST_ABORTING:   nxt = exsm_pkg::ST_ABORTED;
        exsm_pkg::ST_CLEARING:   nxt = exsm_pkg::ST_STOPPED;
        default:                 nxt = cur;  // states without a finish step ignore a finish
      endcase
    end else if (code == exsm_pkg::OR_ABORT) begin
      if (cur != exsm_pkg::ST_ABORTING && cur != exsm_pkg::ST_ABORTED &&
          cur <= exsm_pkg::ST_CLEARING)
        nxt = exsm_pkg::ST_ABORTING;
    end else if (code == exsm_pkg::OR_STOP) begin
      if (!(cur inside {exsm_pkg::ST_STOPPING, exsm_pkg::ST_STOPPED,
                        exsm_pkg::ST_ABORTING, exsm_pkg::ST_ABORTED,
                        exsm_pkg::ST_CLEARING}) && cur <= exsm_pkg::ST_CLEARING)
        nxt = exsm_pkg::ST_STOPPING;
    end else begin
      case (cur)
        exsm_pkg::ST_IDLE:
          if (code == exsm_pkg::OR_START) nxt = exsm_pkg::ST_STARTING;
        exsm_pkg::ST_EXECUTE: begin
          if (code == exsm_pkg::OR_COMPLETE) nxt = exsm_pkg::ST_COMPLETING;
          else if (code == exsm_pkg::OR_HOLD) nxt = exsm_pkg::ST_HOLDING;
          else if (code == exsm_pkg::OR_SUSPEND) nxt = exsm_pkg::ST_SUSPENDING;
        end
        exsm_pkg::ST_COMPLETE, exsm_pkg::ST_STOPPED:
          if (code == exsm_pkg::OR_RESET) nxt = exsm_pkg::ST_RESETTING;
        exsm_pkg::ST_HELD:
          if (code == exsm_pkg::OR_UNHOLD) nxt = exsm_pkg::ST_UNHOLDING;
        exsm_pkg::ST_SUSPENDED:
          if (code == exsm_pkg::OR_UNSUSPEND) nxt = exsm_pkg::ST_UNSUSPENDING;
        exsm_pkg::ST_ABORTED:
          if (code == exsm_pkg::OR_CLEAR) nxt = exsm_pkg::ST_CLEARING;
        default: nxt = cur;
      endcase
    end
    return nxt;
  endfunction

  // Offer one event, with random idle cycles first. Entered and left just
  // after a rising edge. The transfer is seen at the falling edge before the
  // edge that takes it, so the expectation is queued in event order.
  task automatic send_event(logic kind, logic [3:0] code);
    bit                    taken;
    exsm_pkg::exec_state_e nxt;
    state_report_t         rep;
    taken = 1'b0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0000, code};
    while (!taken) begin
      @(negedge clk_i);
      if (s_axis_tready) begin
        taken = 1'b1;
        nxt   = predict_next(tracked_state, kind, code);
        rep.state = nxt;
        rep.moved = (nxt != tracked_state);
        state_reports_q = {state_reports_q, rep};
        tracked_state = nxt;
        events_sent++;
      end
      @(posedge clk_i);
    end
  endtask

  // Drop valid and let every queued report come back.
  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    while (state_reports_q.size() != 0) @(posedge clk_i);
  endtask

  // Walk through every state, every order and the ignored cases: unlisted
  // orders, codes beyond the order set, finish in an end state, and a finish
  // that carries a nonzero order code.
  task automatic test_directed_walk();
    logic [4:0] walk [25];
    walk = '{
      {exsm_pkg::KIND_FINISH, 4'hF},
      {exsm_pkg::KIND_ORDER, 4'hF},
      {exsm_pkg::KIND_ORDER, exsm_pkg::OR_RESET},
      {exsm_pkg::KIND_ORDER, exsm_pkg::OR_START},
      {exsm_pkg::KIND_FINISH, exsm_pkg::OR_ABORT},
      {exsm_pkg::KIND_ORDER, exsm_pkg::OR_HOLD},
      {exsm_pkg::KIND_FINISH, 4'h0},
      {exsm_pkg::KIND_ORDER, exsm_pkg::OR_UNHOLD},
      {exsm_pkg::KIND_FINISH, 4'hA},
      {exsm_pkg::KIND_ORDER, exsm_pkg::OR_SUSPEND},
      {exsm_pkg::KIND_FINISH, 4'h5},
      {exsm_pkg::KIND_ORDER, exsm_pkg::OR_UNSUSPEND},
      {exsm_pkg::KIND_FINISH, 4'h0},
      {exsm_pkg::KIND_ORDER, exsm_pkg::OR_COMPLETE},
      {exsm_pkg::KIND_FINISH, 4'h0},
      {exsm_pkg::KIND_FINISH, 4'h0},
      {exsm_pkg::KIND_ORDER, exsm_pkg::OR_RESET},
      {exsm_pkg::KIND_FINISH, 4'h0},
      {exsm_pkg::KIND_ORDER, exsm_pkg::OR_STOP},
      {exsm_pkg::KIND_FINISH, 4'h0},
      {exsm_pkg::KIND_ORDER, exsm_pkg::OR_ABORT},
      {exsm_pkg::KIND_ORDER, exsm_pkg::OR_CLEAR},
      {exsm_pkg::KIND_FINISH, 4'h0},
      {exsm_pkg::KIND_ORDER, exsm_pkg::OR_CLEAR},
      {exsm_pkg::KIND_FINISH, 4'h0}
    };
    foreach (walk[i]) send_event(walk[i][4], walk[i][3:0]);
    drain_reports();
  endtask

  // Random event sequences: mostly finishes and orders the current state
  // takes, so the walk keeps moving, plus a share of arbitrary codes.
  task automatic test_random_walk(int unsigned count);
    int unsigned pick;
    int unsigned tries;
    logic [3:0]  code;
    repeat (count) begin
      pick = $urandom_range(99);
      code = 4'($urandom_range(15));
      if (pick < 40) begin
        send_event(exsm_pkg::KIND_FINISH, code);
      end else if (pick < 85) begin
        // look for an order that moves the state; aborting takes none
        tries = 0;
        code  = 4'($urandom_range(9));
        while (tries < 16 &&
               predict_next(tracked_state, exsm_pkg::KIND_ORDER, code) == tracked_state)
        begin
          code = 4'($urandom_range(9));
          tries++;
        end
        send_event(exsm_pkg::KIND_ORDER, code);
      end else begin
        send_event(exsm_pkg::KIND_ORDER, code);
      end
    end
    drain_reports();
  endtask

  // Receiver: random back-pressure, driven at the rising edge
  always @(posedge clk_i) begin
    m_axis_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // Result check at the falling edge, where all outputs are settled
  always @(negedge clk_i) begin
    state_report_t rep;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (state_reports_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t: result transfer with none expected: tdata=%h tuser=%b",
                   $realtime, m_axis_tdata, m_axis_tuser);
      end else begin
        rep = state_reports_q.pop_front();
        reports_checked++;
        states_reached[rep.state] = 1'b1;
        if (rep.moved) moves_seen++;
        if (m_axis_tdata !== {3'b000, rep.state} || m_axis_tuser !== rep.moved) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("%0t: mismatch: expected tdata=%h tuser=%b, got tdata=%h tuser=%b",
                     $realtime, {3'b000, rep.state}, rep.moved, m_axis_tdata,
                     m_axis_tuser);
        end
      end
    end
  end

  // Watchdog: too long without a transfer on either side ends the run
  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == StallLimit) begin
        $display("Watchdog: %0d cycles with no transfer, %0d reports outstanding",
                 StallLimit, state_reports_q.size());
        $display("execution_state_machine_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = 8'h00;
    s_axis_tuser    = exsm_pkg::KIND_ORDER;
    m_axis_tready   = 1'b0;
    tracked_state   = exsm_pkg::ST_IDLE;
    send_idle_pct   = 23;
    recv_idle_pct   = 77;
    events_sent     = 0;
    reports_checked = 0;
    moves_seen      = 0;
    mismatch_count  = 0;
    stall_cycles    = 0;
    states_reached  = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender mostly busy, receiver mostly stalling
    test_directed_walk();
    test_random_walk(660);
    // sender mostly idle, receiver mostly ready
    send_idle_pct = 77;
    recv_idle_pct = 23;
    test_random_walk(660);
    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_walk(660);

    repeat (5) @(posedge clk_i);
    if (state_reports_q.size() != 0) begin
      mismatch_count += state_reports_q.size();
      $display("%0d expected state reports never arrived", state_reports_q.size());
    end

    $display("Covered %0d events over three handshake mixes, %0d reports checked, %0d moves.",
             events_sent, reports_checked, moves_seen);
    $display("Reached %0d of 17 execution states, %0d mismatches.",
             $countones(states_reached), mismatch_count);
    if (mismatch_count == 0) begin
      $display("execution_state_machine_unit test passed");
    end else begin
      $display("execution_state_machine_unit test failed");
    end
    $finish;
  end

endmodule
